[src/h264idr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// h264idr_pkg
// shared types and constants for the annex-b idr slice detector
// ----------------------------------------------------------------------------
package h264idr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NalTypeW = 5;
  localparam int unsigned ZeroRunW = 2;

  localparam logic [NalTypeW-1:0] NalTypeIdr    = 5'd5;
  localparam logic [NalTypeW-1:0] NalTypeNonIdr = 5'd1;

  localparam logic [ByteW-1:0]    ByteZero = 8'h00;
  localparam logic [ByteW-1:0]    ByteOne  = 8'h01;

  localparam logic [ZeroRunW-1:0] ZeroRunShort = 2'd2;
  localparam logic [ZeroRunW-1:0] ZeroRunMax   = 2'd3;

  // input request: one buffer byte
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_buffer;
  } in_req_t;

  // output request: verdict for one buffer
  typedef struct packed {
    logic is_idr;
    logic slice_found;
  } out_req_t;

endpackage : h264idr_pkg
`default_nettype wire

[src/h264_idr_slice_detector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// h264_idr_slice_detector
// decides whether an annex-b buffer starts with an idr or non-idr slice
// ----------------------------------------------------------------------------
// Feed the buffer one byte per request, with end_of_buffer set on the last
// byte. The block finds 00 00 01 and 00 00 00 01 start codes and looks at the
// nal header byte after each; the first header of type 5 gives is_idr = 1,
// the first of type 1 gives is_idr = 0, and either sets slice_found. A header
// after a 3-byte start code is ignored when it is the last byte. Exactly one
// output request comes out per buffer, after its last byte, and the block is
// then clear for the next buffer. Throughput is one byte per cycle while
// in_stall_o is low: a byte lands in an input register, the scan logic
// updates the state from it in the following cycle, and the verdict goes to
// an output register. The last byte passes through the input register and
// then the output register before out_valid_o. in_stall_o rises only when a
// last byte waits in the input register while an earlier verdict
// is still stalled at the output.
module h264_idr_slice_detector
  import h264idr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,

  // byte input channel
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,

  // verdict output channel
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o
);

  // input register
  logic     in_valid_q;
  in_req_t  in_req_q;

  // output register
  logic     out_valid_q;
  out_req_t out_req_q;

  logic     out_free;   // output register can take a new verdict this cycle
  logic     advance;    // byte in the input register is consumed this cycle
  logic     in_take;    // new byte accepted from the port
  out_req_t scan_res;

  assign out_free = !out_valid_q || !out_stall_i;

  // non-final bytes never touch the output register, so they always advance
  assign advance    = in_valid_q && (!in_req_q.end_of_buffer || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || advance) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
  end

  h264idr_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_req_q),
    .res_o  (scan_res)
  );

  // output register: loads on a final byte, drains when the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && in_req_q.end_of_buffer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && in_req_q.end_of_buffer) begin
      out_req_q <= scan_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule : h264_idr_slice_detector
`default_nettype wire

[src/h264idr_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// h264idr_scan
// start code tracker and nal header decision, one byte per step
// ----------------------------------------------------------------------------
module h264idr_scan
  import h264idr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_req_t  item_i,
  output out_req_t      res_o
);

  logic [ZeroRunW-1:0] zero_run_q, zero_run_d;
  logic                header_next_q, header_next_d;
  logic                long_sc_q, long_sc_d;
  logic                decided_q, decided_d;
  logic                idr_seen_q, idr_seen_d;

  logic [NalTypeW-1:0] hdr_kind;
  logic                hdr_counts;

  assign hdr_kind   = item_i.data_byte[NalTypeW-1:0];
  assign hdr_counts = header_next_q && !decided_q && (long_sc_q || !item_i.end_of_buffer);

  always_comb begin
    decided_d  = decided_q;
    idr_seen_d = idr_seen_q;
    if (hdr_counts) begin
      if (hdr_kind == NalTypeIdr) begin
        decided_d  = 1'b1;
        idr_seen_d = 1'b1;
      end else if (hdr_kind == NalTypeNonIdr) begin
        decided_d  = 1'b1;
        idr_seen_d = 1'b0;
      end
    end

    header_next_d = 1'b0;
    long_sc_d     = 1'b0;
    if (item_i.data_byte == ByteOne && zero_run_q >= ZeroRunShort) begin
      header_next_d = 1'b1;
      long_sc_d     = (zero_run_q == ZeroRunMax);
    end

    if (item_i.data_byte == ByteZero) begin
      zero_run_d = (zero_run_q == ZeroRunMax) ? zero_run_q : zero_run_q + 2'd1;
    end else begin
      zero_run_d = '0;
    end
  end

  // verdict as of this byte, used only on the final byte
  assign res_o.is_idr      = idr_seen_d & decided_d;
  assign res_o.slice_found = decided_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q    <= '0;
      header_next_q <= 1'b0;
      long_sc_q     <= 1'b0;
      decided_q     <= 1'b0;
      idr_seen_q    <= 1'b0;
    end else if (step_i) begin
      if (item_i.end_of_buffer) begin
        zero_run_q    <= '0;
        header_next_q <= 1'b0;
        long_sc_q     <= 1'b0;
        decided_q     <= 1'b0;
        idr_seen_q    <= 1'b0;
      end else begin
        zero_run_q    <= zero_run_d;
        header_next_q <= header_next_d;
        long_sc_q     <= long_sc_d;
        decided_q     <= decided_d;
        idr_seen_q    <= idr_seen_d;
      end
    end
  end

endmodule : h264idr_scan
`default_nettype wire
